[rtl/core/itad_pkg.sv]
// Shared constants, types and helpers for the integer to ASCII digits unit.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package itad_pkg;

  localparam int VALUE_W    = 32;
  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int MODE_W     = 3;
  localparam int COUNT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_BIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OCT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEC  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEX  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SDEC = 3'd4;

  // Register indexes on the configuration port.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_DEC;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;
  localparam logic [CHAR_W-1:0] CHAR_PLUS   = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2D;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_row_t;

  // Per-value job information handed from the converter to the emitter.
  typedef struct packed {
    logic             signed_mode;
    logic             negative;
    logic [IDX_W-1:0] last_idx;
  } job_t;

  function automatic logic [RADIX_W-1:0] mode_radix(input logic [MODE_W-1:0] m);
    logic [RADIX_W-1:0] r;
    case (m)
      MODE_BIN:  r = 5'd2;
      MODE_OCT:  r = 5'd8;
      MODE_HEX:  r = 5'd16;
      default:   r = 5'd10;
    endcase
    return r;
  endfunction

  function automatic logic mode_valid(input logic [MODE_W-1:0] m);
    return (m == MODE_BIN) || (m == MODE_OCT) || (m == MODE_DEC) ||
           (m == MODE_HEX) || (m == MODE_SDEC);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHAR_LETTER + CHAR_W'(d);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

[rtl/core/integer_to_ascii_digits_unit.sv]
// Top level of the integer to ASCII digits unit: configuration registers,
// converter chain and character emitter. Uses itad_pkg, itad_conv, itad_emit.
//
//   Channel   Signals                          Transfer
//   input     start, busy, value               edge with start high, busy low
//   result    strobe, ascii_char, last         every edge with strobe high
//   config    cfg_write, cfg_index, cfg_data   every edge with cfg_write high
//
// A value shifts through the digit cell chain, then hands its digits to the
// emitter; a new value may start with that hand-over. Characters leave one
// per cycle (digit_count, at least one and at most 32, plus one for the sign
// in signed decimal); the longest text of 33 characters just fits behind the
// next conversion. The first character is on the ports after the shift, the
// hand-over and the output register. Reset is synchronous and restores mode 2
// and a digit count of 6. The receiver cannot stall the result stream.
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [itad_pkg::VALUE_W-1:0] value,
  output logic                              strobe,
  output logic [itad_pkg::CHAR_W-1:0]       ascii_char,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [itad_pkg::COUNT_W-1:0]      cfg_data
);

  logic [itad_pkg::MODE_W-1:0]   mode;
  logic [itad_pkg::COUNT_W-1:0]  digit_count;
  logic                          take;
  logic                          done;
  itad_pkg::job_t                job;
  itad_pkg::digit_row_t          digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= itad_pkg::MODE_RESET;
      digit_count <= itad_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        itad_pkg::REG_MODE:  mode        <= cfg_data[itad_pkg::MODE_W-1:0];
        itad_pkg::REG_COUNT: digit_count <= cfg_data;
        default: ;
      endcase
    end
  end

  itad_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .value       (value),
    .mode        (mode),
    .digit_count (digit_count),
    .take        (take),
    .busy        (busy),
    .done        (done),
    .job         (job),
    .digits      (digits)
  );

  itad_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .job        (job),
    .digits     (digits),
    .take       (take),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last       (last)
  );

endmodule

[rtl/core/itad_cell.sv]
// One digit cell of the converter chain: doubles its digit and adds the bit
// from its lower neighbor each shift, passing the overflow upward. Uses itad_pkg.
`timescale 1ns / 1ps

module itad_cell (
  input  logic                          clk,
  input  logic                          clear,
  input  logic                          shift,
  input  logic                          carry_in,
  input  logic [itad_pkg::RADIX_W-1:0]  radix,
  output logic                          carry_out,
  output logic [itad_pkg::DIGIT_W-1:0]  digit
);

  logic [itad_pkg::RADIX_W-1:0] twice;
  logic [itad_pkg::RADIX_W-1:0] sum;
  logic [itad_pkg::DIGIT_W-1:0] digit_next;

  // The radix is even, so the overflow depends only on this cell's digit and
  // the carries never ripple along the chain.
  assign twice     = {digit, 1'b0};
  assign sum       = {digit, carry_in};
  assign carry_out = (twice >= radix);

  always_comb begin
    if (carry_out) begin
      digit_next = itad_pkg::DIGIT_W'(sum - radix);
    end else begin
      digit_next = itad_pkg::DIGIT_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (shift) begin
      digit <= digit_next;
    end
  end

endmodule

[rtl/core/itad_conv.sv]
// Converter: shifts the value into a chain of itad_cell digit cells, one bit
// per cycle, most significant bit first. Uses itad_pkg and itad_cell.
`timescale 1ns / 1ps

module itad_conv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [itad_pkg::VALUE_W-1:0]      value,
  input  logic [itad_pkg::MODE_W-1:0]       mode,
  input  logic [itad_pkg::COUNT_W-1:0]      digit_count,
  input  logic                              take,
  output logic                              busy,
  output logic                              done,
  output itad_pkg::job_t                    job,
  output itad_pkg::digit_row_t              digits
);

  logic                             active;
  logic [itad_pkg::CNT_W-1:0]       cnt;
  logic [itad_pkg::VALUE_W-1:0]     sreg;
  logic [itad_pkg::RADIX_W-1:0]     radix;
  logic                             go;
  logic                             negative;
  logic [itad_pkg::VALUE_W-1:0]     magnitude;
  logic [itad_pkg::IDX_W-1:0]       last_idx;
  logic [itad_pkg::MAX_DIGITS:0]    carry;

  // The emitter may pick up the finished digits in the same cycle that a new
  // value starts; the cells still hold the old digits at that edge.
  assign busy = active | (done & ~take);
  assign go   = start & ~busy & itad_pkg::mode_valid(mode);

  assign negative  = (mode == itad_pkg::MODE_SDEC) & value[itad_pkg::VALUE_W-1];
  assign magnitude = negative ? (~value + itad_pkg::VALUE_W'(1)) : value;

  always_comb begin
    if (digit_count == '0) begin
      last_idx = '0;
    end else if (digit_count > itad_pkg::COUNT_W'(itad_pkg::MAX_DIGITS)) begin
      last_idx = itad_pkg::IDX_W'(itad_pkg::MAX_DIGITS - 1);
    end else begin
      last_idx = itad_pkg::IDX_W'(digit_count - itad_pkg::COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      if (take) begin
        done <= 1'b0;
      end
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + itad_pkg::CNT_W'(1);
        if (cnt == itad_pkg::CNT_W'(itad_pkg::VALUE_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sreg             <= magnitude;
      radix            <= itad_pkg::mode_radix(mode);
      job.signed_mode  <= (mode == itad_pkg::MODE_SDEC);
      job.negative     <= negative;
      job.last_idx     <= last_idx;
    end else if (active) begin
      sreg <= {sreg[itad_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign carry[0] = sreg[itad_pkg::VALUE_W-1];

  for (genvar i = 0; i < itad_pkg::MAX_DIGITS; i++) begin : g_cell
    itad_cell u_cell (
      .clk       (clk),
      .clear     (go),
      .shift     (active),
      .carry_in  (carry[i]),
      .radix     (radix),
      .carry_out (carry[i+1]),
      .digit     (digits[i])
    );
  end

endmodule

[rtl/core/itad_emit.sv]
// Emitter: holds one converted value and sends its sign and digits out one
// character per cycle, most significant first. Uses itad_pkg.
`timescale 1ns / 1ps

module itad_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           done,
  input  itad_pkg::job_t                 job,
  input  itad_pkg::digit_row_t           digits,
  output logic                           take,
  output logic                           strobe,
  output logic [itad_pkg::CHAR_W-1:0]    ascii_char,
  output logic                           last
);

  logic                        active;
  logic                        sign_pend;
  logic                        negative;
  logic [itad_pkg::IDX_W-1:0]  idx;
  itad_pkg::digit_row_t        held;
  logic                        final_char;

  assign final_char = active & ~sign_pend & (idx == '0);
  assign take       = done & (~active | final_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (take) begin
        active <= 1'b1;
      end else if (final_char) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (sign_pend) begin
        ascii_char <= negative ? itad_pkg::CHAR_MINUS : itad_pkg::CHAR_PLUS;
        last       <= 1'b0;
      end else begin
        ascii_char <= itad_pkg::digit_char(held[idx]);
        last       <= (idx == '0);
      end
    end
    if (take) begin
      held      <= digits;
      idx       <= job.last_idx;
      sign_pend <= job.signed_mode;
      negative  <= job.negative;
    end else if (active) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - itad_pkg::IDX_W'(1);
      end
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench for integer_to_ascii_digits_unit: directed and random values over varied
// modes and digit counts, each character checked against an in-bench predictor.
// Depends on rtl/core/itad_pkg.sv and the unit's RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import itad_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 100;
  localparam int PHASE_ITEMS  = 20;
  localparam int RAND_PHASES  = 19;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [VALUE_W-1:0] value = '0;
  logic strobe;
  logic [CHAR_W-1:0] ascii_char;
  logic last;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_MODE;
  logic [COUNT_W-1:0] cfg_data = '0;

  logic [VALUE_W-1:0] value_q[$];
  text_char_t         char_q[$];
  logic [MODE_W-1:0]  cur_mode;
  logic [COUNT_W-1:0] cur_count;
  logic               item_taken = 1'b0;
  int                 idle_pct = 0;
  int                 queued_cnt = 0;
  int                 accepted_cnt = 0;
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;

  integer_to_ascii_digits_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last       (last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Works out the text of one value under the current settings and queues it.
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    int unsigned radix;
    int unsigned x;
    int          n;
    int          i;
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    text_char_t  c;
    case (cur_mode)
      MODE_BIN: radix = 2;
      MODE_OCT: radix = 8;
      MODE_DEC, MODE_SDEC: radix = 10;
      MODE_HEX: radix = 16;
      default: return;
    endcase
    n = int'(cur_count);
    if (n < 1) n = 1;
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    x = v;
    if (cur_mode == MODE_SDEC) begin
      c.code = v[VALUE_W-1] ? CHAR_MINUS : CHAR_PLUS;
      c.last = 1'b0;
      char_q.push_back(c);
      if (v[VALUE_W-1]) x = ~v + 1;
    end
    for (i = 0; i < n; i++) begin
      digs[i] = DIGIT_W'(x % radix);
      x = x / radix;
    end
    for (i = n - 1; i >= 0; i--) begin
      c.code = (digs[i] > 4'd9) ? CHAR_LETTER + CHAR_W'(digs[i])
                                : CHAR_ZERO + CHAR_W'(digs[i]);
      c.last = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  // Driver: presents the next pending value, holding it until the transfer.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (value_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        value <= value_q.pop_front();
      end else begin
        start <= 1'b0;
        value <= $urandom;
      end
    end
  end

  // Monitor: tracks the registers, predicts on each transfer, checks characters.
  always @(posedge clk) begin : monitor
    text_char_t exp_c;
    item_taken <= start && !busy && !rst;
    if (rst) begin
      cur_mode  = MODE_RESET;
      cur_count = COUNT_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MODE) begin
          cur_mode = cfg_data[MODE_W-1:0];
        end else begin
          cur_count = cfg_data;
        end
      end
      if (start && !busy) begin
        predict_text(value);
        accepted_cnt++;
      end
      if (strobe) begin
        if (char_q.size() == 0) begin
          $error("unexpected character: ascii_char %0h last %0b", ascii_char, last);
          err_cnt++;
        end else begin
          exp_c = char_q.pop_front();
          if (ascii_char !== exp_c.code) begin
            $error("ascii_char: expected %0h, got %0h", exp_c.code, ascii_char);
            err_cnt++;
          end
          if (last !== exp_c.last) begin
            $error("last: expected %0b, got %0b", exp_c.last, last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_item(input logic [VALUE_W-1:0] v);
    value_q.push_back(v);
    queued_cnt++;
  endtask

  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // A value taken in a reserved mode leaves nothing to wait for; a fixed
  // settle time follows anyway so that the registers change on an idle block.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || char_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] m, input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] mdata;
    wait_idle();
    // Upper data bits are don't-care for the mode register.
    mdata = {3'($urandom_range(0, 1) ? $urandom : 0), m};
    write_reg(REG_MODE, mdata);
    write_reg(REG_COUNT, cnt);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2, 3: v = $urandom;
      4: v = $urandom_range(0, 1000);
      5: v = -$urandom_range(1, 1000);
      6: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: v = 32'h1 << $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    logic [COUNT_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = 6'd0;
      1: c = 6'd1;
      2: c = 6'd32;
      3: c = COUNT_W'($urandom_range(33, 63));
      4, 5: c = COUNT_W'($urandom_range(1, 4));
      default: c = COUNT_W'($urandom_range(1, 32));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    int p;
    int k;
    int r;
    logic [MODE_W-1:0] m;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: unsigned decimal with six digits.
    push_item(32'd0);
    push_item(32'd123456);
    push_item(32'hFFFF_FFFF);

    // Signed decimal, including the most negative value.
    set_config(MODE_SDEC, 6'd10);
    push_item(32'h8000_0000);
    push_item(32'h7FFF_FFFF);
    push_item(32'hFFFF_FFFF);
    push_item(32'd0);
    set_config(MODE_SDEC, 6'd1);
    push_item(32'h8000_0000);

    // Hex letters A to F.
    set_config(MODE_HEX, 6'd8);
    push_item(32'hFEDC_BA98);
    push_item(32'h0123_ABCD);

    set_config(MODE_BIN, 6'd32);
    push_item(32'hFFFF_FFFF);
    push_item(32'h5555_5555);

    // A count of zero behaves as one; the top octal digit is truncated.
    set_config(MODE_OCT, 6'd0);
    push_item(32'h0000_000F);
    // Counts above the maximum saturate; places beyond the value read zero.
    set_config(MODE_OCT, 6'd63);
    push_item(32'hFFFF_FFFF);
    set_config(MODE_DEC, 6'd33);
    push_item(32'hFFFF_FFFF);

    // Reserved modes produce no characters.
    set_config(3'd5, 6'd4);
    push_item(32'd1);
    set_config(3'd7, 6'd4);
    push_item(32'd2);

    for (p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(0, 15);
      m = (r < 13) ? MODE_W'(r % 5) : MODE_W'(r - 8);
      set_config(m, rand_count());
      case (p % 4)
        1: idle_pct = 84;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) push_item(rand_value());
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[integer_to_ascii_digits_unit.f]
rtl/core/itad_pkg.sv
rtl/core/itad_cell.sv
rtl/core/itad_conv.sv
rtl/core/itad_emit.sv
rtl/core/integer_to_ascii_digits_unit.sv
tb/tb_top.sv
